### rtl/atlr_pkg.sv
package atlr_pkg;

	localparam int CW = 9;       // pixel coordinate after rounding
	localparam int XW = 13;      // signed walk coordinate
	localparam int EW = 24;      // signed walk error
	localparam int HW = 13;      // half width in 1/32 pixel
	localparam int RW = 17;      // line length in Q.8
	localparam int QW = 26;      // coverage quotient bits
	localparam int DIMW = 13;    // clamped image dimension
	localparam int QDEPTH = 2;

	typedef enum logic [1:0] {
		OP_DRAW   = 2'd0,
		OP_READ   = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_UNUSED = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CFG_WIDTH    = 2'd0,
		CFG_HEIGHT   = 2'd1,
		CFG_MAXVAL   = 2'd2,
		CFG_DILATION = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_DRAW,
		CMD_READ,
		CMD_READ_OUT,
		CMD_CLEAR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t       kind;
		logic [CW-1:0]   x0;
		logic [CW-1:0]   y0;
		logic [CW-1:0]   x1;
		logic [CW-1:0]   y1;
		logic [HW-1:0]   h;
		logic [7:0]      rcol;
		logic [7:0]      rrow;
	} cmd_t;

	typedef enum logic [4:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLR,
		ST_RD0,
		ST_RD1,
		ST_SET0,
		ST_SET1,
		ST_SET2,
		ST_SET3,
		ST_SQW,
		ST_TOP,
		ST_YCHK,
		ST_YIN,
		ST_YINS,
		ST_YEND,
		ST_XCHK,
		ST_XIN,
		ST_XINS,
		ST_XEND,
		ST_PSTART,
		ST_PDIV,
		ST_PMUL,
		ST_PWR,
		ST_DONE
	} back_state_t;

	typedef enum logic [1:0] {
		RET_YCHK,
		RET_YSTEP,
		RET_XSTEP
	} ret_t;

	function automatic logic [DIMW-1:0] dim_clamp(input logic [8:0] w, input logic [DIMW-1:0] lim);
		logic [DIMW-1:0] we;
		we = DIMW'(w);
		return (we > lim) ? lim : we;
	endfunction

endpackage

### rtl/atlr_front.sv
module atlr_front (
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            operation,
	input  logic [11:0]           start_x,
	input  logic [11:0]           start_y,
	input  logic [11:0]           end_x,
	input  logic [11:0]           end_y,
	input  logic [11:0]           thickness,
	input  logic [7:0]            read_column,
	input  logic [7:0]            read_row,
	input  logic [12:0]           cols,
	input  logic [12:0]           rows,
	input  logic [7:0]            line_dilation,
	input  logic                  q_full,
	input  logic                  init_busy,
	output logic                  push,
	output atlr_pkg::cmd_t        cmd
);
	import atlr_pkg::*;

	logic [12:0] lim_x, lim_y;
	logic        ok;

	function automatic logic [CW-1:0] rnd(input logic [11:0] c);
		logic [12:0] s;
		s = 13'(c) + 13'd8;
		return CW'(s >> 4);
	endfunction

	// cols and rows stay below 512 here, so x16 fits
	assign lim_x = 13'({cols, 4'b0});
	assign lim_y = 13'({rows, 4'b0});

	assign ok = (start_x != 12'd0) && (13'(start_x) < lim_x) &&
	            (start_y != 12'd0) && (13'(start_y) < lim_y) &&
	            (end_x != 12'd0) && (13'(end_x) < lim_x) &&
	            (end_y != 12'd0) && (13'(end_y) < lim_y);

	assign in_ready = !q_full && !init_busy;
	assign push = in_valid && in_ready;

	always_comb begin
		cmd.x0 = rnd(start_x);
		cmd.y0 = rnd(start_y);
		cmd.x1 = rnd(end_x);
		cmd.y1 = rnd(end_y);
		cmd.h = HW'(thickness) + HW'({line_dilation, 4'b0}) + HW'(16);
		cmd.rcol = read_column;
		cmd.rrow = read_row;
		unique case (op_t'(operation))
			OP_DRAW: begin
				cmd.kind = ok ? CMD_DRAW : CMD_NONE;
			end
			OP_READ: begin
				cmd.kind = ((13'(read_column) >= cols) || (13'(read_row) >= rows)) ?
				           CMD_READ_OUT : CMD_READ;
			end
			OP_CLEAR: begin
				cmd.kind = CMD_CLEAR;
			end
			default: begin
				cmd.kind = CMD_NONE;
			end
		endcase
	end

endmodule

### rtl/atlr_fifo.sv
module atlr_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  atlr_pkg::cmd_t din,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output atlr_pkg::cmd_t dout
);
	import atlr_pkg::*;

	localparam int PW = $clog2(QDEPTH);
	localparam int NW = $clog2(QDEPTH + 1);

	cmd_t          ent_q [QDEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [NW-1:0] cnt_q;

	assign full = (cnt_q == NW'(QDEPTH));
	assign valid = (cnt_q != '0);
	assign dout = ent_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop) rptr_q <= rptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wptr_q] <= din;
	end

endmodule

### rtl/atlr_sqrt.sv
module atlr_sqrt (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [17:0]   d2,
	output logic          done,
	output logic [atlr_pkg::RW-1:0] root
);
	import atlr_pkg::*;

	logic [2*RW-1:0] rad_q;
	logic [RW-1:0]   root_q;
	logic [RW+1:0]   rem_q;
	logic [4:0]      cnt_q;
	logic            busy_q, done_q;
	logic [RW+3:0]   t, trial;

	// radicand is d2 * 65536; one root bit per cycle
	assign t = {rem_q, rad_q[2*RW-1 -: 2]};
	assign trial = (RW+4)'({root_q, 2'b01});
	assign done = done_q;
	assign root = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == 5'(RW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= (2*RW)'({d2, 16'b0});
			root_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			rad_q <= rad_q << 2;
			if (t >= trial) begin
				rem_q <= (RW+2)'(t - trial);
				root_q <= {root_q[RW-2:0], 1'b1};
			end else begin
				rem_q <= (RW+2)'(t);
				root_q <= {root_q[RW-2:0], 1'b0};
			end
		end
	end

endmodule

### rtl/atlr_div.sv
module atlr_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [atlr_pkg::EW-1:0] mag,
	input  logic [atlr_pkg::RW-1:0] den,
	output logic                    done,
	output logic                    ovf,
	output logic [atlr_pkg::QW-1:0] quo
);
	import atlr_pkg::*;

	// quotient of (mag << 24) / den, QW bits; ovf when it needs more
	logic [EW-3:0] hi;
	logic [RW-1:0] rem_q;
	logic [QW-1:0] num_q, quo_q;
	logic [4:0]    cnt_q;
	logic          busy_q, done_q, ovf_q;
	logic [RW:0]   t;

	assign hi = mag[EW-1:2];
	assign t = {rem_q, num_q[QW-1]};
	assign done = done_q;
	assign ovf = ovf_q;
	assign quo = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == 5'(QW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ovf_q <= ((EW-2)'(den) <= hi);
			rem_q <= ((EW-2)'(den) <= hi) ? '0 : RW'(hi);
			num_q <= {mag[1:0], {(QW-2){1'b0}}};
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			if (t >= (RW+1)'(den)) begin
				rem_q <= RW'(t - (RW+1)'(den));
				quo_q <= {quo_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= RW'(t);
				quo_q <= {quo_q[QW-2:0], 1'b0};
			end
		end
	end

endmodule

### rtl/atlr_back.sv
module atlr_back #(
	parameter int MAX_COLUMNS = 256,
	parameter int MAX_ROWS = 256,
	parameter int PIXEL_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  atlr_pkg::cmd_t q_cmd,
	output logic           q_pop,
	input  logic [12:0]    cols,
	input  logic [12:0]    rows,
	input  logic [15:0]    max_value,
	output logic           init_busy,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [15:0]    pixel_value,
	output logic           line_drawn,
	output logic           read_outside
);
	import atlr_pkg::*;

	localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
	localparam int AW = $clog2(DEPTH);
	localparam int SW = ((PIXEL_BITS > 16) ? PIXEL_BITS : 16) + 1;
	localparam logic [15:0] PMASK = (PIXEL_BITS >= 16) ? 16'hFFFF :
	                                16'((32'd1 << PIXEL_BITS) - 32'd1);

	back_state_t state_q, state_n;
	ret_t        ret_q;
	cmd_t        cmd_q;

	logic [PIXEL_BITS-1:0] mem [DEPTH];
	logic [PIXEL_BITS-1:0] rdata_q, mem_wdata;
	logic [AW-1:0]         clr_q, mem_waddr, mem_raddr, paddr, raddr;
	logic                  mem_we, mem_re;

	logic [CW-1:0]         dx_q, dy_q;
	logic signed [XW-1:0]  sx_q, sy_q;
	logic signed [XW-1:0]  bx0_q, bx1_q, by0_q, by1_q, cx_q, cy_q, ex_q, ey_q;
	logic signed [XW-1:0]  offx_q, offy_q, dx0_q, pos_q, pix_x_q, pix_y_q;
	logic [17:0]           dxx_q, dyy_q, d2_q;
	logic [25:0]           hh_q;
	logic [43:0]           d2hh_q;
	logic signed [EW-1:0]  pxo_q, pyo_q, err_q, derr_q, e2_q, pix_e_q;
	logic [47:0]           aa_q;
	logic                  zero_q, full_q;
	logic [31:0]           prod_q;
	logic [15:0]           res_pix_q, pix_out_q;
	logic                  res_drawn_q, res_out_q, drawn_out_q, outside_out_q;
	logic                  out_valid_q, out_load;

	logic signed [EW-1:0]  dxs, dys;
	logic signed [EW:0]    err2;
	logic [EW-1:0]         eabs, pabs;
	logic                  ychk, xchk, y_inb, x_inb, in_line;
	logic [15:0]           mval, cov;
	logic [23:0]           wq, dd;
	logic [SW-1:0]         sum;
	logic                  sq_start, sq_done, div_start, div_done, div_ovf;
	logic [RW-1:0]         s8;
	logic [QW-1:0]         div_q;

	logic signed [XW-1:0]  x0s, x1s, y0s, y1s, wis, hix, hiy;
	logic signed [XW-1:0]  bx0_c, bx1_c, by0_c, by1_c, cx_c, cy_c, ex_c, ey_c;
	logic signed [XW-1:0]  offx_c, offy_c;

	function automatic logic signed [XW-1:0] clampc(input logic signed [XW-1:0] v,
	                                                input logic signed [XW-1:0] hi);
		logic signed [XW-1:0] r;
		r = v;
		if (r < 0) r = '0;
		if (r > hi) r = hi;
		return r;
	endfunction

	atlr_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.d2     (d2_q),
		.done   (sq_done),
		.root   (s8)
	);

	atlr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.mag    (pabs),
		.den    (s8),
		.done   (div_done),
		.ovf    (div_ovf),
		.quo    (div_q)
	);

	assign mval = (max_value > PMASK) ? PMASK : max_value;
	assign dxs = $signed(EW'(dx_q));
	assign dys = $signed(EW'(dy_q));
	assign err2 = {err_q, 1'b0};
	assign ychk = (err2 + $signed((EW+1)'(dx_q))) >= 0;
	assign xchk = err2 <= $signed((EW+1)'(dy_q));
	assign y_inb = (pos_q >= by0_q) && (pos_q <= by1_q);
	assign x_inb = (pos_q >= bx0_q) && (pos_q <= bx1_q);
	assign eabs = e2_q[EW-1] ? unsigned'(-e2_q) : unsigned'(e2_q);
	assign pabs = pix_e_q[EW-1] ? unsigned'(-pix_e_q) : unsigned'(pix_e_q);
	// inside the line: 1024 * e^2 < D2 * H^2
	assign in_line = {aa_q, 10'b0} < 58'(d2hh_q);
	assign wq = {cmd_q.h, 11'b0};
	assign dd = wq - div_q[23:0];
	assign cov = zero_q ? 16'd0 : (full_q ? mval : prod_q[31:16]);
	assign sum = SW'(rdata_q) + SW'(cov);
	assign paddr = AW'(32'(pix_y_q[XW-2:0]) * 32'(MAX_COLUMNS) + 32'(pix_x_q[XW-2:0]));
	assign raddr = AW'(32'(cmd_q.rrow) * 32'(MAX_COLUMNS) + 32'(cmd_q.rcol));

	// walk bounds, clipped to the image and widened by the whole half width
	always_comb begin
		x0s = $signed(XW'(cmd_q.x0));
		x1s = $signed(XW'(cmd_q.x1));
		y0s = $signed(XW'(cmd_q.y0));
		y1s = $signed(XW'(cmd_q.y1));
		wis = $signed(XW'(cmd_q.h >> 5));
		hix = $signed(cols - 13'd1);
		hiy = $signed(rows - 13'd1);
		if (cmd_q.x0 < cmd_q.x1) begin
			bx0_c = clampc(x0s - wis, hix);
			bx1_c = clampc(x1s + wis, hix);
			offx_c = x0s - bx0_c;
			cx_c = bx0_c;
			ex_c = bx1_c;
		end else begin
			bx0_c = clampc(x1s - wis, hix);
			bx1_c = clampc(x0s + wis, hix);
			offx_c = bx1_c - x0s;
			cx_c = bx1_c;
			ex_c = bx0_c;
		end
		if (cmd_q.y0 < cmd_q.y1) begin
			by0_c = clampc(y0s - wis, hiy);
			by1_c = clampc(y1s + wis, hiy);
			offy_c = y0s - by0_c;
			cy_c = by0_c;
			ey_c = by1_c;
		end else begin
			by0_c = clampc(y1s - wis, hiy);
			by1_c = clampc(y0s + wis, hiy);
			offy_c = by1_c - y0s;
			cy_c = by1_c;
			ey_c = by0_c;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_INIT: if (clr_q == AW'(DEPTH - 1)) state_n = ST_IDLE;
			ST_IDLE: begin
				if (q_valid) begin
					unique case (q_cmd.kind)
						CMD_CLEAR: state_n = ST_CLR;
						CMD_READ:  state_n = ST_RD0;
						CMD_DRAW:  state_n = ST_SET0;
						default:   state_n = ST_DONE;
					endcase
				end
			end
			ST_CLR:    if (clr_q == AW'(DEPTH - 1)) state_n = ST_DONE;
			ST_RD0:    state_n = ST_RD1;
			ST_RD1:    state_n = ST_DONE;
			ST_SET0:   state_n = ST_SET1;
			ST_SET1:   state_n = ST_SET2;
			ST_SET2:   state_n = ST_SET3;
			ST_SET3:   state_n = ST_SQW;
			ST_SQW:    if (sq_done) state_n = ST_TOP;
			ST_TOP:    state_n = ST_PSTART;
			ST_YCHK:   state_n = ychk ? ST_YIN : ST_XCHK;
			ST_YIN:    state_n = y_inb ? ST_YINS : ST_YEND;
			ST_YINS:   state_n = in_line ? ST_PSTART : ST_YEND;
			ST_YEND:   state_n = (cx_q == ex_q) ? ST_DONE : ST_XCHK;
			ST_XCHK:   state_n = xchk ? ST_XIN : ST_TOP;
			ST_XIN:    state_n = x_inb ? ST_XINS : ST_XEND;
			ST_XINS:   state_n = in_line ? ST_PSTART : ST_XEND;
			ST_XEND:   state_n = (cy_q == ey_q) ? ST_DONE : ST_TOP;
			ST_PSTART: state_n = ST_PDIV;
			ST_PDIV:   if (div_done) state_n = ST_PMUL;
			ST_PMUL:   state_n = ST_PWR;
			ST_PWR: begin
				unique case (ret_q)
					RET_YCHK:  state_n = ST_YCHK;
					RET_YSTEP: state_n = ST_YIN;
					default:   state_n = ST_XIN;
				endcase
			end
			ST_DONE:   if (!out_valid_q || out_ready) state_n = ST_IDLE;
			default:   state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop = (state_q == ST_IDLE) && q_valid;
		sq_start = (state_q == ST_SET3);
		div_start = (state_q == ST_PSTART);
		out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);
		init_busy = (state_q == ST_INIT);
		mem_we = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		mem_re = 1'b0;
		mem_raddr = paddr;
		unique case (state_q)
			ST_INIT, ST_CLR: mem_we = 1'b1;
			ST_RD0: begin
				mem_re = 1'b1;
				mem_raddr = raddr;
			end
			ST_PSTART: mem_re = 1'b1;
			ST_PWR: begin
				mem_we = 1'b1;
				mem_waddr = paddr;
				mem_wdata = (sum > SW'(mval)) ? PIXEL_BITS'(mval) : PIXEL_BITS'(sum);
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == ST_INIT || state_q == ST_CLR)
				clr_q <= (clr_q == AW'(DEPTH - 1)) ? '0 : clr_q + 1'b1;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pix_out_q <= res_pix_q;
			drawn_out_q <= res_drawn_q;
			outside_out_q <= res_out_q;
		end
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					cmd_q <= q_cmd;
					res_drawn_q <= (q_cmd.kind == CMD_DRAW);
					res_out_q <= (q_cmd.kind == CMD_READ_OUT);
					res_pix_q <= '0;
				end
			end
			ST_RD1: res_pix_q <= 16'(rdata_q);
			ST_SET0: begin
				dx_q <= (cmd_q.x0 < cmd_q.x1) ? cmd_q.x1 - cmd_q.x0 : cmd_q.x0 - cmd_q.x1;
				dy_q <= (cmd_q.y0 < cmd_q.y1) ? cmd_q.y1 - cmd_q.y0 : cmd_q.y0 - cmd_q.y1;
				sx_q <= (cmd_q.x0 < cmd_q.x1) ? XW'(1) : -XW'(1);
				sy_q <= (cmd_q.y0 < cmd_q.y1) ? XW'(1) : -XW'(1);
				bx0_q <= bx0_c;
				bx1_q <= bx1_c;
				by0_q <= by0_c;
				by1_q <= by1_c;
				cx_q <= cx_c;
				cy_q <= cy_c;
				ex_q <= ex_c;
				ey_q <= ey_c;
				offx_q <= offx_c;
				offy_q <= offy_c;
			end
			ST_SET1: begin
				dxx_q <= dx_q * dx_q;
				dyy_q <= dy_q * dy_q;
				hh_q <= cmd_q.h * cmd_q.h;
				pxo_q <= offx_q * $signed({1'b0, dy_q});
				pyo_q <= offy_q * $signed({1'b0, dx_q});
			end
			ST_SET2: begin
				d2_q <= ((dx_q == '0) && (dy_q == '0)) ? 18'd1 : dxx_q + dyy_q;
				err_q <= dxs - dys + pxo_q - pyo_q;
				derr_q <= '0;
				dx0_q <= '0;
			end
			ST_SET3: d2hh_q <= d2_q * hh_q;
			ST_TOP: begin
				err_q <= err_q + derr_q;
				derr_q <= '0;
				cx_q <= cx_q + dx0_q;
				dx0_q <= '0;
				pix_x_q <= cx_q + dx0_q;
				pix_y_q <= cy_q;
				pix_e_q <= err_q + derr_q - dxs + dys;
				ret_q <= RET_YCHK;
			end
			ST_YCHK: begin
				e2_q <= err_q + dys;
				pos_q <= cy_q + sy_q;
			end
			ST_YIN, ST_XIN: aa_q <= eabs * eabs;
			ST_YINS: begin
				pix_x_q <= cx_q;
				pix_y_q <= pos_q;
				pix_e_q <= e2_q;
				ret_q <= RET_YSTEP;
			end
			ST_YEND: begin
				derr_q <= derr_q - dys;
				dx0_q <= dx0_q + sx_q;
			end
			ST_XCHK: begin
				e2_q <= err_q - dxs;
				pos_q <= cx_q + sx_q;
			end
			ST_XINS: begin
				pix_x_q <= pos_q;
				pix_y_q <= cy_q;
				pix_e_q <= e2_q;
				ret_q <= RET_XSTEP;
			end
			ST_XEND: begin
				derr_q <= derr_q + dxs;
				cy_q <= cy_q + sy_q;
			end
			ST_PMUL: begin
				zero_q <= div_ovf || (div_q >= QW'(wq));
				full_q <= (dd[23:16] != 8'd0);
				prod_q <= mval * dd[15:0];
			end
			ST_PWR: begin
				if (ret_q == RET_YSTEP) begin
					e2_q <= e2_q + dxs;
					pos_q <= pos_q + sy_q;
				end else if (ret_q == RET_XSTEP) begin
					e2_q <= e2_q - dys;
					pos_q <= pos_q + sx_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign pixel_value = pix_out_q;
	assign line_drawn = drawn_out_q;
	assign read_outside = outside_out_q;

endmodule

### rtl/antialiased_thick_line_raster_core.sv
// Channel   Handshake              Payload
// in        in_valid / in_ready    operation, start_x..end_y, thickness, read_column, read_row
// out       out_valid / out_ready  pixel_value, line_drawn, read_outside
// cfg       cfg_we                 cfg_index, cfg_data
//
// After reset the image store is cleared, one pixel a cycle, over all
// MAX_COLUMNS*MAX_ROWS locations; in_ready stays low during that pass.
// In the walker a read passes RD0, RD1 and DONE, a rejected item goes straight to DONE, and a
// clear sweeps every location in CLR before DONE. A draw runs setup SET0 to SET3 and the
// length square root (one bit a cycle), then per touched pixel a read, the bit-serial coverage
// divider, a multiply and a write-back, plus inside tests of the width loops and walk steps.
// A two-entry queue sits between intake and the walker; a full result
// register holds the walker while intake keeps filling the queue.
module antialiased_thick_line_raster_core #(
	parameter int MAX_COLUMNS = 256,
	parameter int MAX_ROWS = 256,
	parameter int PIXEL_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [11:0] start_x,
	input  logic [11:0] start_y,
	input  logic [11:0] end_x,
	input  logic [11:0] end_y,
	input  logic [11:0] thickness,
	input  logic [7:0]  read_column,
	input  logic [7:0]  read_row,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] pixel_value,
	output logic        line_drawn,
	output logic        read_outside,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import atlr_pkg::*;

	logic [8:0]  width_q, height_q;
	logic [15:0] maxval_q;
	logic [7:0]  dil_q;
	logic [12:0] cols, rows;
	logic        q_full, q_valid, q_pop, push, init_busy;
	cmd_t        cmd_in, cmd_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 9'd256;
			height_q <= 9'd256;
			maxval_q <= 16'd255;
			dil_q <= 8'd0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_WIDTH:    width_q <= cfg_data[8:0];
				CFG_HEIGHT:   height_q <= cfg_data[8:0];
				CFG_MAXVAL:   maxval_q <= cfg_data;
				CFG_DILATION: dil_q <= cfg_data[7:0];
				default:      dil_q <= dil_q;
			endcase
		end
	end

	assign cols = dim_clamp(width_q, DIMW'(MAX_COLUMNS));
	assign rows = dim_clamp(height_q, DIMW'(MAX_ROWS));

	atlr_front u_front (
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.start_x       (start_x),
		.start_y       (start_y),
		.end_x         (end_x),
		.end_y         (end_y),
		.thickness     (thickness),
		.read_column   (read_column),
		.read_row      (read_row),
		.cols          (cols),
		.rows          (rows),
		.line_dilation (dil_q),
		.q_full        (q_full),
		.init_busy     (init_busy),
		.push          (push),
		.cmd           (cmd_in)
	);

	atlr_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (cmd_in),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.dout   (cmd_out)
	);

	atlr_back #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS),
		.PIXEL_BITS  (PIXEL_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_cmd        (cmd_out),
		.q_pop        (q_pop),
		.cols         (cols),
		.rows         (rows),
		.max_value    (maxval_q),
		.init_busy    (init_busy),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_value  (pixel_value),
		.line_drawn   (line_drawn),
		.read_outside (read_outside)
	);

endmodule
